// ===== sv/pver_pkg.sv =====
// Shared types and constants for the packed voxel entry reader.
package pver_pkg;

    localparam int COORD_W   = 10;
    localparam int EXT_W     = 11;
    localparam int BPE_W     = 5;
    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int WORD_BITS = 64;
    localparam int BIT_SEL_W = 6;      // log2 of WORD_BITS
    localparam int ENTRY_W   = 31;
    localparam int STATUS_W  = 2;
    localparam int LIN_W     = 33;
    localparam int BITADDR_W = 38;
    localparam int WADDR_W   = BITADDR_W - BIT_SEL_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_ENTRY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COORD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [INDEX_W-1:0]     word_index;
        logic [WORD_BITS-1:0]   word_data;
        logic [COORD_W-1:0]     coord_x;
        logic [COORD_W-1:0]     coord_y;
        logic [COORD_W-1:0]     coord_z;
    } pver_in_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]     entry_value;
        logic [STATUS_W-1:0]    status;
    } pver_out_t;

    // Effective configuration after clamping
    typedef struct packed {
        logic [EXT_W-1:0]       sx;
        logic [EXT_W-1:0]       sy;
        logic [EXT_W-1:0]       sz;
        logic [BPE_W-1:0]       width;
        logic [COUNT_W-1:0]     limit;
    } pver_cfg_t;

    // Lookup descriptor handed from address stage to store and on to extraction
    typedef struct packed {
        logic                   valid;
        logic [STATUS_W-1:0]    status;
        logic [BIT_SEL_W-1:0]   shift;
        logic [BPE_W-1:0]       width;
    } pver_req_t;

endpackage

// ===== sv/pver_addr.sv =====
// Address pipeline: linear index, bit address, word address and limit check.
module pver_addr
    import pver_pkg::*;
#(
    parameter int STORE_WORDS = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [COORD_W-1:0]                coord_x,
    input  logic [COORD_W-1:0]                coord_y,
    input  logic [COORD_W-1:0]                coord_z,
    input  pver_cfg_t                         cfg,
    output pver_req_t                         req,
    output logic [$clog2(STORE_WORDS)-1:0]    word_addr,
    output logic                              active
);

    localparam int AW = $clog2(STORE_WORDS);

    // stage 1: partial products
    logic                   v1_reg;
    logic                   err1_reg;
    logic [2*EXT_W-2:0]     ysx1_reg;
    logic [2*EXT_W-2:0]     zsx1_reg;
    logic [COORD_W-1:0]     x1_reg;
    // stage 2: linear index
    logic                   v2_reg;
    logic                   err2_reg;
    logic [LIN_W-1:0]       lin2_reg;
    // stage 3: bit address
    logic                   v3_reg;
    logic                   err3_reg;
    logic [BITADDR_W-1:0]   bit3_reg;

    logic                   coord_err;
    logic [LIN_W-2:0]       prod2;
    logic [LIN_W-1:0]       lin_next;
    logic [BITADDR_W-1:0]   end_bit;
    logic [WADDR_W-1:0]     last_word;
    logic                   over_limit;

    assign coord_err = ({1'b0, coord_x} >= cfg.sx) || ({1'b0, coord_y} >= cfg.sy)
                    || ({1'b0, coord_z} >= cfg.sz);

    assign prod2    = ysx1_reg * cfg.sz;
    assign lin_next = LIN_W'(prod2) + LIN_W'(zsx1_reg) + LIN_W'(x1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        err1_reg <= coord_err;
        ysx1_reg <= coord_y * cfg.sx;
        zsx1_reg <= coord_z * cfg.sx;
        x1_reg   <= coord_x;
        err2_reg <= err1_reg;
        lin2_reg <= lin_next;
        err3_reg <= err2_reg;
        bit3_reg <= lin2_reg * cfg.width;
    end

    // last word the entry touches
    assign end_bit    = bit3_reg + BITADDR_W'(cfg.width) - BITADDR_W'(1);
    assign last_word  = end_bit[BITADDR_W-1:BIT_SEL_W];
    assign over_limit = last_word >= WADDR_W'(cfg.limit);

    always_comb
    begin
        req.valid = v3_reg;
        req.shift = bit3_reg[BIT_SEL_W-1:0];
        req.width = cfg.width;
        if (err3_reg)
            req.status = ST_COORD;
        else if (over_limit)
            req.status = ST_LIMIT;
        else
            req.status = ST_OK;
    end

    // in range whenever status is ok, since limit never exceeds STORE_WORDS
    assign word_addr = bit3_reg[BIT_SEL_W+AW-1:BIT_SEL_W];
    assign active    = v1_reg | v2_reg | v3_reg;

endmodule

// ===== sv/pver_store.sv =====
// Word store split into even and odd banks so both words of an entry read together.
module pver_store
    import pver_pkg::*;
#(
    parameter int STORE_WORDS = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [$clog2(STORE_WORDS)-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0]              wr_data,
    input  pver_req_t                         req,
    input  logic [$clog2(STORE_WORDS)-1:0]    rd_addr,
    output pver_req_t                         rd_meta,
    output logic [WORD_BITS-1:0]              rd_lo,
    output logic [WORD_BITS-1:0]              rd_hi
);

    localparam int DEP_E = (STORE_WORDS + 1) / 2;
    localparam int DEP_O = STORE_WORDS / 2;
    localparam int RW    = (DEP_E > 1) ? $clog2(DEP_E) : 1;

    logic [WORD_BITS-1:0] even_mem [DEP_E];
    logic [WORD_BITS-1:0] odd_mem  [DEP_O];

    logic [WORD_BITS-1:0] even_q_reg;
    logic [WORD_BITS-1:0] odd_q_reg;
    logic                 odd_first_reg;
    pver_req_t            meta_reg;

    logic [RW:0]          wr_ext;
    logic [RW:0]          rd_ext;
    logic [RW-1:0]        wr_row;
    logic [RW-1:0]        rd_row;
    logic [RW-1:0]        even_row;
    logic                 rd_en;

    assign wr_ext   = (RW+1)'(wr_addr);
    assign rd_ext   = (RW+1)'(rd_addr);
    assign wr_row   = wr_ext[RW:1];
    assign rd_row   = rd_ext[RW:1];
    // odd first word: the following even word sits one row up
    assign even_row = rd_addr[0] ? rd_row + RW'(1) : rd_row;
    assign rd_en    = req.valid && (req.status == ST_OK);

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_addr[0])
            even_mem[wr_row] <= wr_data;
        if (wr_en && wr_addr[0])
            odd_mem[wr_row] <= wr_data;
        if (rd_en)
        begin
            even_q_reg    <= even_mem[even_row];
            odd_q_reg     <= odd_mem[rd_row];
            odd_first_reg <= rd_addr[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta_reg <= '0;
        else
            meta_reg <= req;
    end

    assign rd_meta = meta_reg;
    assign rd_lo   = odd_first_reg ? odd_q_reg : even_q_reg;
    assign rd_hi   = odd_first_reg ? even_q_reg : odd_q_reg;

endmodule

// ===== sv/packed_voxel_entry_reader_core.sv =====
// Top level of the packed voxel entry reader: config registers, sequencing and extraction.
//
// Packed palette-index reader. A transaction is accepted at a rising edge with
// start high and busy low. A load (mode 0) writes one 64-bit word into the store
// in that same edge and produces no result; busy stays low, so loads can follow
// every cycle. A lookup (mode 1) raises busy and delivers one result: result_valid
// is high for exactly one cycle and the receiver cannot hold it off. The lookup
// passes the three multiply stages of the address pipeline (y*sx and z*sx, then
// the linear index, then the bit address), then one read of the even and odd
// word banks and the field extraction register. A new transaction may be accepted
// in the cycle the result is shown. The store has no reset; reading a word never
// loaded gives an undefined entry. Status 1 flags a coordinate at or beyond its
// extent, status 2 an entry whose last word lies at or beyond word_count capped to
// the store size; entry_value is zero for any nonzero status. Configuration must
// be written only while busy is low.
module packed_voxel_entry_reader_core
    import pver_pkg::*;
#(
    parameter int STORE_WORDS = 4096,
    parameter int MAX_EXTENT  = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  pver_in_t                item,
    output logic                    result_valid,
    output pver_out_t               result,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(STORE_WORDS);

    // configuration registers
    logic [EXT_W-1:0]   size_x_reg;
    logic [EXT_W-1:0]   size_y_reg;
    logic [EXT_W-1:0]   size_z_reg;
    logic [BPE_W-1:0]   bpe_reg;
    logic [COUNT_W-1:0] word_count_reg;

    pver_cfg_t          cfg;

    logic               accept;
    logic               lookup_go;
    logic               load_en;
    logic [AW-1:0]      load_addr;

    pver_req_t          req;
    logic [AW-1:0]      rd_addr;
    logic               addr_active;
    pver_req_t          rd_meta;
    logic [WORD_BITS-1:0] rd_lo;
    logic [WORD_BITS-1:0] rd_hi;

    logic [2*WORD_BITS-1:0] pair;
    logic [2*WORD_BITS-1:0] shifted;
    logic [ENTRY_W-1:0]     mask;

    logic               result_valid_reg;
    pver_out_t          result_reg;
    pver_out_t          result_next;

    // ---- configuration port ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg     <= EXT_W'(1);
            size_y_reg     <= EXT_W'(1);
            size_z_reg     <= EXT_W'(1);
            bpe_reg        <= BPE_W'(2);
            word_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SIZE_X:     size_x_reg     <= cfg_wdata[EXT_W-1:0];
                REG_SIZE_Y:     size_y_reg     <= cfg_wdata[EXT_W-1:0];
                REG_SIZE_Z:     size_z_reg     <= cfg_wdata[EXT_W-1:0];
                REG_BITS_ENTRY: bpe_reg        <= cfg_wdata[BPE_W-1:0];
                REG_WORD_COUNT: word_count_reg <= cfg_wdata;
                default:        ;   // unmapped index, write dropped
            endcase
        end
    end

    // Effective values: extents clamp to MAX_EXTENT, width floors at 2,
    // word count clamps to the store size.
    always_comb
    begin
        cfg.sx = (32'(size_x_reg) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : size_x_reg;
        cfg.sy = (32'(size_y_reg) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : size_y_reg;
        cfg.sz = (32'(size_z_reg) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : size_z_reg;
        cfg.width = (bpe_reg < BPE_W'(2)) ? BPE_W'(2) : bpe_reg;
        cfg.limit = (32'(word_count_reg) > 32'(STORE_WORDS)) ? COUNT_W'(STORE_WORDS)
                                                              : word_count_reg;
    end

    // ---- transaction acceptance ----
    assign accept    = start && !busy;
    assign lookup_go = accept && (item.mode == MODE_LOOKUP);
    // loads outside the store are dropped
    assign load_en   = accept && (item.mode == MODE_LOAD)
                    && (32'(item.word_index) < 32'(STORE_WORDS));
    assign load_addr = AW'(item.word_index);

    // busy covers the address pipeline and the bank read, so no load can
    // overtake a lookup's read of the same word
    assign busy = addr_active | rd_meta.valid;

    pver_addr #(
        .STORE_WORDS (STORE_WORDS)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (lookup_go),
        .coord_x   (item.coord_x),
        .coord_y   (item.coord_y),
        .coord_z   (item.coord_z),
        .cfg       (cfg),
        .req       (req),
        .word_addr (rd_addr),
        .active    (addr_active)
    );

    pver_store #(
        .STORE_WORDS (STORE_WORDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_addr (load_addr),
        .wr_data (item.word_data),
        .req     (req),
        .rd_addr (rd_addr),
        .rd_meta (rd_meta),
        .rd_lo   (rd_lo),
        .rd_hi   (rd_hi)
    );

    // ---- field extraction ----
    // The high word only contributes when the entry spans two words; otherwise
    // its bits land above the width mask.
    assign pair    = {rd_hi, rd_lo};
    assign shifted = pair >> rd_meta.shift;
    // a width of 31 wraps to zero then to all ones
    assign mask    = (ENTRY_W'(1) << rd_meta.width) - ENTRY_W'(1);

    always_comb
    begin
        result_next.status = rd_meta.status;
        if (rd_meta.status == ST_OK)
            result_next.entry_value = shifted[ENTRY_W-1:0] & mask;
        else
            result_next.entry_value = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= rd_meta.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---- assertions ----
    // every lookup yields its result strobe
    a_lookup_latency: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_go |-> ##5 result_valid)
        else $error("lookup result missing after five cycles");

    // results only come from lookups, never from loads
    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(rd_meta.valid))
        else $error("result strobe without a bank read");

    // the pipeline has drained by the time the result is shown
    a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(lookup_go, 4) |-> !busy)
        else $error("busy still high while result is shown");

    // an error status always carries a zero entry
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_COORD || result.status == ST_LIMIT)
        |-> result.entry_value == '0)
        else $error("nonzero entry with error status");

endmodule

// ===== tb/packed_voxel_entry_reader_core_tb.sv =====
// Self-checking testbench for the packed voxel entry reader: directed and random loads and lookups.
module packed_voxel_entry_reader_core_tb;
    import pver_pkg::*;

    localparam int     STORE_WORDS    = 4096;
    localparam int     MAX_EXTENT     = 1024;
    localparam int     CLK_PERIOD     = 8;
    localparam int     RESET_CYCLES   = 11;
    localparam int     SETTLE_CYCLES  = 8;    // lookup latency plus margin
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_ITEMS    = 216;
    localparam int     MAX_GAP        = 14;
    localparam longint TIMEOUT_CYCLES = 1000000;

    // Predicts the entry for each accepted lookup and checks results in order.
    class entry_checker;
        logic [EXT_W-1:0]     size_x;
        logic [EXT_W-1:0]     size_y;
        logic [EXT_W-1:0]     size_z;
        logic [BPE_W-1:0]     bits_per_entry;
        logic [COUNT_W-1:0]   word_count;
        logic [WORD_BITS-1:0] words [STORE_WORDS];
        bit                   loaded [STORE_WORDS];
        pver_out_t            pending_entries [$];
        int                   errors;

        function new();
            size_x         = 1;
            size_y         = 1;
            size_z         = 1;
            bits_per_entry = 2;
            word_count     = 0;
            errors         = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SIZE_X:     size_x = data[EXT_W-1:0];
                REG_SIZE_Y:     size_y = data[EXT_W-1:0];
                REG_SIZE_Z:     size_z = data[EXT_W-1:0];
                REG_BITS_ENTRY: bits_per_entry = data[BPE_W-1:0];
                REG_WORD_COUNT: word_count = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned extent(input logic [EXT_W-1:0] s);
            return (s > MAX_EXTENT) ? MAX_EXTENT : s;
        endfunction

        function int unsigned entry_width();
            return (bits_per_entry < 2) ? 2 : bits_per_entry;
        endfunction

        function longint unsigned word_limit();
            return (word_count > STORE_WORDS) ? STORE_WORDS : word_count;
        endfunction

        // Number of linear indexes that land inside both the region and the word limit
        function longint unsigned entry_span();
            longint unsigned total;
            longint unsigned by_words;
            total    = extent(size_x) * extent(size_y) * extent(size_z);
            by_words = word_limit() * WORD_BITS / entry_width();
            return (total < by_words) ? total : by_words;
        endfunction

        function void coords_of(input longint unsigned lin, output logic [COORD_W-1:0] x,
                                output logic [COORD_W-1:0] y, output logic [COORD_W-1:0] z);
            longint unsigned sx;
            longint unsigned sz;
            sx = extent(size_x);
            sz = extent(size_z);
            x  = lin % sx;
            z  = (lin / sx) % sz;
            y  = lin / (sx * sz);
        endfunction

        // Status, the words touched and the bit offset of a lookup
        function void locate(input pver_in_t it, output logic [STATUS_W-1:0] st,
                             output int unsigned w0, output int unsigned w1,
                             output int unsigned sh, output int unsigned wd);
            longint unsigned sx;
            longint unsigned sy;
            longint unsigned sz;
            longint unsigned lin;
            longint unsigned first_bit;
            sx = extent(size_x);
            sy = extent(size_y);
            sz = extent(size_z);
            wd = entry_width();
            w0 = 0;
            w1 = 0;
            sh = 0;
            if (it.coord_x >= sx || it.coord_y >= sy || it.coord_z >= sz) begin
                st = ST_COORD;
            end
            else begin
                lin       = longint'(it.coord_y) * sx * sz + longint'(it.coord_z) * sx
                            + longint'(it.coord_x);
                first_bit = lin * wd;
                w0        = first_bit / WORD_BITS;
                w1        = (first_bit + wd - 1) / WORD_BITS;
                sh        = first_bit % WORD_BITS;
                st        = (w1 >= word_limit()) ? ST_LIMIT : ST_OK;
            end
        endfunction

        function pver_out_t extract_entry(input pver_in_t it);
            pver_out_t            r;
            logic [STATUS_W-1:0]  st;
            int unsigned          w0;
            int unsigned          w1;
            int unsigned          sh;
            int unsigned          wd;
            logic [WORD_BITS-1:0] v;
            locate(it, st, w0, w1, sh, wd);
            r.status      = st;
            r.entry_value = '0;
            if (st == ST_OK) begin
                v = words[w0] >> sh;
                if (w1 != w0)
                    v = v | (words[w1] << (WORD_BITS - sh));
                v = v & ((64'd1 << wd) - 64'd1);
                r.entry_value = v[ENTRY_W-1:0];
            end
            return r;
        endfunction

        function void note_transaction(input pver_in_t it);
            if (it.mode == MODE_LOAD) begin
                if (it.word_index < STORE_WORDS) begin
                    words[it.word_index]  = it.word_data;
                    loaded[it.word_index] = 1'b1;
                end
            end
            else begin
                pending_entries.push_back(extract_entry(it));
            end
        endfunction

        function void check_result(input pver_out_t got);
            pver_out_t exp;
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected result, got value %h status %0d",
                         $time, got.entry_value, got.status);
                errors++;
            end
            else begin
                exp = pending_entries.pop_front();
                if (got.entry_value !== exp.entry_value || got.status !== exp.status) begin
                    $display("%0t: entry mismatch, expected value %h status %0d, got value %h status %0d",
                             $time, exp.entry_value, exp.status, got.entry_value, got.status);
                    errors++;
                end
            end
        endfunction

        function void close();
            if (pending_entries.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, pending_entries.size());
                errors++;
            end
        endfunction
    endclass

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         start        = 1'b0;
    logic         busy;
    pver_in_t     item         = '0;
    logic         result_valid;
    pver_out_t    result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    entry_checker chk;
    int           gap_max = MAX_GAP;

    always #(CLK_PERIOD / 2) clk = ~clk;

    packed_voxel_entry_reader_core #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_EXTENT  (MAX_EXTENT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    // Results cannot be held off: take each one at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (result_valid === 1'b1)
            chk.check_result(result);
    end

    // Holds start high from its rising edge until the transaction is taken; start only
    // drops when a gap is drawn, so back-to-back transactions never toggle it in one step.
    task automatic send_item(input pver_in_t it);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        chk.note_transaction(it);
    endtask

    function automatic pver_in_t random_item();
        pver_in_t it;
        it.mode       = $urandom_range(0, 1);
        it.word_index = $urandom_range(0, STORE_WORDS - 1);
        it.word_data  = {$urandom, $urandom};
        it.coord_x    = $urandom_range(0, 1023);
        it.coord_y    = $urandom_range(0, 1023);
        it.coord_z    = $urandom_range(0, 1023);
        return it;
    endfunction

    task automatic send_load(input int unsigned idx, input logic [WORD_BITS-1:0] data);
        pver_in_t it;
        it            = random_item();
        it.mode       = MODE_LOAD;
        it.word_index = idx;
        it.word_data  = data;
        send_item(it);
    endtask

    // The store is undefined until loaded, so any word a lookup will read is loaded first.
    task automatic issue_lookup(input pver_in_t it);
        logic [STATUS_W-1:0] st;
        int unsigned         w0;
        int unsigned         w1;
        int unsigned         sh;
        int unsigned         wd;
        it.mode = MODE_LOOKUP;
        chk.locate(it, st, w0, w1, sh, wd);
        if (st == ST_OK) begin
            if (!chk.loaded[w0])
                send_load(w0, {$urandom, $urandom});
            if (!chk.loaded[w1])
                send_load(w1, {$urandom, $urandom});
        end
        send_item(it);
    endtask

    task automatic send_lookup(input int unsigned x, input int unsigned y, input int unsigned z);
        pver_in_t it;
        it         = random_item();
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        issue_lookup(it);
    endtask

    task automatic lookup_at(input longint unsigned lin);
        pver_in_t it;
        it = random_item();
        chk.coords_of(lin, it.coord_x, it.coord_y, it.coord_z);
        issue_lookup(it);
    endtask

    // Sender pauses until every result is in, then lets the pipeline settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (chk.pending_entries.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        chk.set_reg(idx, data);
    endtask

    // Only called while idle; write enable stays high across the five writes.
    task automatic configure(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                             input logic [CFG_DATA_W-1:0] sz, input logic [CFG_DATA_W-1:0] bpe,
                             input logic [CFG_DATA_W-1:0] wc);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        write_reg(REG_BITS_ENTRY, bpe);
        write_reg(REG_WORD_COUNT, wc);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 1;
            2:       return MAX_EXTENT;
            3:       return $urandom_range(MAX_EXTENT + 1, 2047);
            4, 5:    return $urandom_range(1, MAX_EXTENT);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 31;
            default: return $urandom_range(2, 31);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return STORE_WORDS;
            2:       return $urandom_range(STORE_WORDS + 1, 8191);
            3:       return $urandom_range(1, 64);
            default: return $urandom_range(1, STORE_WORDS);
        endcase
    endfunction

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("packed_voxel_entry_reader_core test failed");
        $finish;
    end

    initial
    begin
        int              sel;
        longint unsigned reach;
        longint unsigned lin;
        longint unsigned lim;
        pver_in_t        it;

        chk = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no valid words, so an in-range lookup trips the word limit,
        // and a lookup failing both checks must report the coordinate error.
        send_lookup(0, 0, 0);
        send_lookup(1023, 1023, 1023);
        wait_drained();

        // Oversized x extent, widest entries, word count beyond the store
        configure(2047, MAX_EXTENT, MAX_EXTENT, 31, 8191);
        send_load(0, '1);
        send_load(1, 64'h5555_aaaa_0f0f_f0f0);
        send_load(STORE_WORDS - 1, 64'h8000_0000_0000_0001);
        send_lookup(0, 0, 0);
        send_lookup(2, 0, 0);                 // straddles words 0 and 1
        send_lookup(1023, 0, 0);
        send_lookup(1023, 1023, 1023);        // far past the last word
        lookup_at(chk.entry_span() - 1);      // last entry that fits the store
        lookup_at(chk.entry_span());          // one past it
        wait_drained();

        // Zero z extent rejects everything; width 0 behaves as 2
        configure(5, 3, 0, 0, 100);
        send_lookup(0, 0, 0);
        send_lookup(4, 2, 0);
        wait_drained();

        // Width 1 behaves as 2: a single word holds exactly 32 entries
        configure(64, 1, 1, 1, 1);
        lookup_at(0);
        lookup_at(31);
        lookup_at(32);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure(pick_extent(), pick_extent(), pick_extent(), pick_width(), pick_count());
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel   = $urandom_range(0, 99);
                reach = chk.entry_span();
                lim   = chk.word_limit();
                if (sel == 0)
                    wait_drained();
                if (sel < 25) begin
                    if (lim != 0 && $urandom_range(0, 2) != 0)
                        send_load($urandom_range(0, int'(lim) - 1), {$urandom, $urandom});
                    else
                        send_load($urandom_range(0, STORE_WORDS - 1), {$urandom, $urandom});
                end
                else if (sel < 85 && reach != 0) begin
                    // Well-formed lookup, mostly inside the valid range, edges now and then
                    case ($urandom_range(0, 9))
                        0:       lin = reach - 1;
                        1:       lin = reach;
                        default: lin = $urandom_range(0, int'(reach - 1));
                    endcase
                    lookup_at(lin);
                end
                else begin
                    it = random_item();
                    if ($urandom_range(0, 1) == 0) begin
                        it.coord_x = $urandom_range(0, 20);
                        it.coord_y = $urandom_range(0, 20);
                        it.coord_z = $urandom_range(0, 20);
                    end
                    issue_lookup(it);
                end
            end
            wait_drained();
        end

        chk.close();
        if (chk.errors == 0)
            $display("packed_voxel_entry_reader_core test passed");
        else
            $display("packed_voxel_entry_reader_core test failed");
        $finish;
    end

endmodule
